// ===== design/dtp_pkg.sv =====
// ----------------------------------------------------------------------------
// dtp_pkg: shared types and constants of the decimal text parser
// Parse phases, status codes, character constants and the result record.
// ----------------------------------------------------------------------------
package dtp_pkg;

    // Parse phase of the current text
    typedef enum logic [2:0] {
        PH_LEAD    = 3'd0,
        PH_SIGN    = 3'd1,
        PH_DIGITS  = 3'd2,
        PH_TRAIL   = 3'd3,
        PH_GARBAGE = 3'd4
    } phase_t;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int VALUE_W = 64;
    // Accumulator width with headroom for one multiply by ten plus a digit
    localparam int ACC_W   = VALUE_W + 4;

    // One result transaction
    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] value;
    } result_t;

    // Control from the input stage to the parse core
    typedef struct packed {
        logic       go;
        logic [7:0] ch;
        logic       last;
    } step_t;

endpackage

// ===== design/decimal_text_to_int64_parser.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_int64_parser: streaming decimal text to signed 64-bit value
// Parses one text byte per transaction and returns status and value.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side carries one text byte per transaction in s_tdata, with s_tlast
//   on the final byte of a text. Master side carries one result transaction
//   per text: status (0 ok, 1 invalid, 2 overflow) and the 64-bit value.
//   Bytes enter an input register, the parse core advances its state by one
//   byte per cycle (multiply by ten, add and range check), and the result of
//   a text is loaded into the output register.
//   Throughput: one byte per cycle while no final byte waits for the output
//   register, as set by the registered state update loop.
//   Reset clears the parse state and both stage valid flags; no result is
//   pending afterwards. When the receiver stalls, non-final bytes still flow
//   through; a final byte waits in the input register until the output
//   register is free, and s_tready then drops.
// ----------------------------------------------------------------------------
module decimal_text_to_int64_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [1:0] status, [65:2] value, [71:66] zero
);
    import dtp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    core_result;
    step_t      step;
    logic       out_free;

    // Input stage hands a byte to the core unless a final byte must wait
    assign out_free  = !out_valid_reg || m_tready;
    assign step.go   = in_valid_reg && (!in_last_reg || out_free);
    assign step.ch   = in_ch_reg;
    assign step.last = in_last_reg;
    assign s_tready  = !in_valid_reg || step.go;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_ch_reg   <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    dtp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .result (core_result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step.go && step.last)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step.go && step.last)
            out_reg <= core_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.value, out_reg.status};

endmodule

// ===== design/dtp_core.sv =====
// ----------------------------------------------------------------------------
// dtp_core: parse state and per-byte step logic
// Holds phase, sign, signed accumulator and flags; advances them by one byte
// per step and forms the result of the text from the updated state.
// ----------------------------------------------------------------------------
module dtp_core (
    input  logic             clk,
    input  logic             rst_n,
    input  dtp_pkg::step_t   step,
    output dtp_pkg::result_t result
);
    import dtp_pkg::*;

    phase_t                    phase_reg, phase_next;
    logic                      negative_reg, negative_next;
    logic signed [VALUE_W-1:0] acc_reg, acc_next;
    logic                      ovf_reg, ovf_next;
    logic                      ended_reg, ended_next;

    logic                      is_space, is_digit, is_sign, take_digit;
    logic signed [ACC_W-1:0]   acc_ext, times10, acc_sum;
    logic [ACC_W-1:0]          digit_ext;
    logic                      sum_fits;

    // Character classes
    assign is_space = (step.ch == CH_SPACE) || (step.ch >= CH_TAB && step.ch <= CH_CR);
    assign is_digit = (step.ch >= CH_ZERO) && (step.ch <= CH_NINE);
    assign is_sign  = (step.ch == CH_PLUS) || (step.ch == CH_MINUS);

    // Phase next state; a NUL byte or an ended text freezes the phase
    always_comb
    begin
        phase_next = phase_reg;
        take_digit = 1'b0;
        if (!ended_reg && step.ch != CH_NUL)
        begin
            unique case (phase_reg)
                PH_LEAD:
                begin
                    if (is_space)
                        phase_next = PH_LEAD;
                    else if (is_sign)
                        phase_next = PH_SIGN;
                    else if (is_digit)
                    begin
                        phase_next = PH_DIGITS;
                        take_digit = 1'b1;
                    end
                    else
                        phase_next = PH_GARBAGE;
                end
                PH_SIGN:
                begin
                    if (is_digit)
                    begin
                        phase_next = PH_DIGITS;
                        take_digit = 1'b1;
                    end
                    else
                        phase_next = PH_GARBAGE;
                end
                PH_DIGITS:
                begin
                    if (is_digit)
                        take_digit = 1'b1;
                    else if (is_space)
                        phase_next = PH_TRAIL;
                    else
                        phase_next = PH_GARBAGE;
                end
                PH_TRAIL:
                begin
                    if (!is_space)
                        phase_next = PH_GARBAGE;
                end
                default:
                    phase_next = PH_GARBAGE;
            endcase
        end
    end

    // Accumulate the signed value directly: acc*10 + d, or acc*10 - d
    assign acc_ext   = {{(ACC_W-VALUE_W){acc_reg[VALUE_W-1]}}, acc_reg};
    assign times10   = (acc_ext <<< 3) + (acc_ext <<< 1);
    assign digit_ext = {{(ACC_W-4){1'b0}}, step.ch[3:0]};
    assign acc_sum   = negative_reg ? (times10 - $signed(digit_ext))
                                    : (times10 + $signed(digit_ext));
    // Fits in 64 bits when the headroom bits all match the sign bit
    assign sum_fits  = (acc_sum[ACC_W-1:VALUE_W-1] == {(ACC_W-VALUE_W+1){1'b0}})
                    || (acc_sum[ACC_W-1:VALUE_W-1] == {(ACC_W-VALUE_W+1){1'b1}});

    // Datapath next state
    always_comb
    begin
        negative_next = negative_reg;
        acc_next      = acc_reg;
        ovf_next      = ovf_reg;
        ended_next    = ended_reg;
        if (!ended_reg)
        begin
            if (step.ch == CH_NUL)
                ended_next = 1'b1;
            else if (phase_reg == PH_LEAD && is_sign)
                negative_next = (step.ch == CH_MINUS);
        end
        if (take_digit && !ovf_reg)
        begin
            if (sum_fits)
                acc_next = acc_sum[VALUE_W-1:0];
            else
                ovf_next = 1'b1;
        end
    end

    // Result of the text from the updated state
    always_comb
    begin
        result.value = '0;
        if (ovf_next)
            result.status = ST_OVERFLOW;
        else if (phase_next == PH_DIGITS || phase_next == PH_TRAIL)
        begin
            result.status = ST_OK;
            result.value  = acc_next;
        end
        else
            result.status = ST_INVALID;
    end

    // State registers; the last byte of a text returns them to reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LEAD;
            negative_reg <= 1'b0;
            acc_reg      <= '0;
            ovf_reg      <= 1'b0;
            ended_reg    <= 1'b0;
        end
        else if (step.go)
        begin
            if (step.last)
            begin
                phase_reg    <= PH_LEAD;
                negative_reg <= 1'b0;
                acc_reg      <= '0;
                ovf_reg      <= 1'b0;
                ended_reg    <= 1'b0;
            end
            else
            begin
                phase_reg    <= phase_next;
                negative_reg <= negative_next;
                acc_reg      <= acc_next;
                ovf_reg      <= ovf_next;
                ended_reg    <= ended_next;
            end
        end
    end

endmodule
